// ===== rtl/xorshift128plus_generator_assert.svh =====
// Assertion macros for the xorshift128+ generator checker.
// No dependencies; included by files that assert.
`ifndef XORSHIFT128PLUS_GENERATOR_ASSERT_SVH
`define XORSHIFT128PLUS_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define XS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xorshift128+ check failed");

// Next-cycle implication, disabled during reset.
`define XS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xorshift128+ check failed");

`endif

// ===== rtl/xs128p_pkg.sv =====
// Shared types and constants for the xorshift128+ generator.
// No dependencies.
package xs128p_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  // murmur3 finalizer multipliers and shift amount, then xorshift128+ shift amounts
  localparam logic [WordW-1:0] MixMulOne = 64'hff51afd7ed558ccd;
  localparam logic [WordW-1:0] MixMulTwo = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MixShift = 33;
  localparam int unsigned XsShiftA = 23;
  localparam int unsigned XsShiftB = 17;
  localparam int unsigned XsShiftC = 26;

  typedef struct packed {
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
  } xs_in_t;

  typedef struct packed {
    logic        [63:0] raw_draw;
    logic signed [31:0] ranged_draw;
  } xs_out_t;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD_SEED = 4'd1,
    OP_LOAD_A    = 4'd2,
    OP_XSHIFT    = 4'd3,
    OP_MUL       = 4'd4,
    OP_FINAL_A   = 4'd5,
    OP_FINAL_B   = 4'd6,
    OP_STEP      = 4'd7,
    OP_DIV       = 4'd8,
    OP_RESULT    = 4'd9
  } xs_op_e;

  typedef struct packed {
    xs_op_e     op;
    logic [1:0] mul_phase;  // which 32x32 partial product
    logic       mul_second; // 1: second finalizer multiplier
  } xs_cmd_t;

  typedef struct packed {
    logic div_last;
  } xs_status_t;

endpackage

// ===== rtl/xs128p_datapath.sv =====
// Datapath: state words, seed, finalizer multiply, xorshift step, remainder unit.
// Depends on xs128p_pkg.
module xs128p_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 seed_we_i,
  input  logic [63:0]          seed_i,
  input  xs128p_pkg::xs_in_t   in_i,
  input  xs128p_pkg::xs_cmd_t  cmd_i,
  output xs128p_pkg::xs_status_t status_o,
  output xs128p_pkg::xs_out_t  out_o
);
  import xs128p_pkg::*;

  logic [WordW-1:0]   seed_q;
  logic [WordW-1:0]   word_a_q, word_b_q;
  logic [WordW-1:0]   hash_q, prod_q;
  logic [WordW-1:0]   raw_q, dvd_q;
  logic [HalfW-1:0]   rem_q, span_q;
  logic signed [31:0] min_q;
  logic [DivCntW-1:0] div_cnt_q;
  xs_out_t            out_q;

  logic [WordW-1:0] mix_const, hash_xs, prod, prod_sum;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [WordW-1:0] xs_x1, xs_x2, xs_x3, xs_raw;
  logic [HalfW-1:0] diff, mag;
  logic [HalfW:0]   rem_shift, rem_sub;
  logic             rem_ge;
  logic [HalfW-1:0] rem_final;

  // seed register: reset value is part of the contract
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  // finalizer: one shared 32x32 multiplier, three partial products per 64-bit multiply
  assign mix_const = cmd_i.mul_second ? MixMulTwo : MixMulOne;
  assign hash_xs   = hash_q ^ (hash_q >> MixShift);

  always_comb begin
    case (cmd_i.mul_phase)
      2'd0: begin
        mul_a = hash_q[HalfW-1:0];
        mul_b = mix_const[HalfW-1:0];
      end
      2'd1: begin
        mul_a = hash_q[HalfW-1:0];
        mul_b = mix_const[WordW-1:HalfW];
      end
      default: begin
        mul_a = hash_q[WordW-1:HalfW];
        mul_b = mix_const[HalfW-1:0];
      end
    endcase
  end

  assign prod     = WordW'(mul_a) * WordW'(mul_b);
  assign prod_sum = prod_q + {prod[HalfW-1:0], {HalfW{1'b0}}};

  // xorshift128+ step
  assign xs_x1  = word_a_q ^ (word_a_q << XsShiftA);
  assign xs_x2  = xs_x1 ^ (xs_x1 >> XsShiftB);
  assign xs_x3  = xs_x2 ^ word_b_q ^ (word_b_q >> XsShiftC);
  assign xs_raw = xs_x3 + word_b_q;

  // span = |max - min| + 1 in 32-bit wraparound
  assign diff = HalfW'(in_i.range_max) - HalfW'(in_i.range_min);
  assign mag  = diff[HalfW-1] ? (HalfW'(0) - diff) : diff;

  // restoring remainder, one dividend bit per cycle
  assign rem_shift = {rem_q, dvd_q[WordW-1]};
  assign rem_sub   = rem_shift - {1'b0, span_q};
  assign rem_ge    = rem_shift >= {1'b0, span_q};
  // zero span passes the draw unreduced
  assign rem_final = (span_q == '0) ? raw_q[HalfW-1:0] : rem_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_SEED: hash_q <= {seed_q[WordW-2:0], 1'b1};
      OP_LOAD_A:    hash_q <= word_a_q;
      OP_XSHIFT:    hash_q <= hash_xs;
      OP_MUL: begin
        if (cmd_i.mul_phase == 2'd0) begin
          prod_q <= prod;
        end else if (cmd_i.mul_phase == 2'd1) begin
          prod_q <= prod_sum;
        end else begin
          hash_q <= prod_sum;
        end
      end
      OP_FINAL_A: word_a_q <= hash_xs;
      OP_FINAL_B: word_b_q <= hash_xs;
      OP_STEP: begin
        word_a_q  <= word_b_q;
        word_b_q  <= xs_x3;
        raw_q     <= xs_raw;
        dvd_q     <= xs_raw;
        rem_q     <= '0;
        span_q    <= mag + HalfW'(1);
        min_q     <= in_i.range_min;
        div_cnt_q <= '0;
      end
      OP_DIV: begin
        rem_q     <= rem_ge ? rem_sub[HalfW-1:0] : rem_shift[HalfW-1:0];
        dvd_q     <= {dvd_q[WordW-2:0], 1'b0};
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      OP_RESULT: begin
        out_q.raw_draw    <= raw_q;
        out_q.ranged_draw <= signed'(HalfW'(min_q) + rem_final);
      end
      default: ;
    endcase
  end

  assign status_o.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign out_o             = out_q;

endmodule

// ===== rtl/xs128p_ctrl.sv =====
// Controller: sequences seed reload, draw step, remainder loop and output beat.
// Depends on xs128p_pkg.
module xs128p_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output xs128p_pkg::xs_cmd_t    cmd_o,
  input  xs128p_pkg::xs_status_t status_i
);
  import xs128p_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_X1   = 9'b000000100,
    S_M1   = 9'b000001000,
    S_X2   = 9'b000010000,
    S_M2   = 9'b000100000,
    S_FIN  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       pass_q, pass_d;   // 0: word a, 1: word b
  logic       out_valid_q, out_valid_d;
  logic       idle, cfg_take, in_take, out_load;

  assign idle        = (state_q == S_IDLE);
  assign cfg_ready_o = idle;
  assign cfg_take    = idle && cfg_valid_i;
  // config has priority in idle
  assign in_stall_o  = !idle || cfg_valid_i;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d          = state_q;
    phase_d          = phase_q;
    pass_d           = pass_q;
    cmd_o.op         = OP_NONE;
    cmd_o.mul_phase  = phase_q;
    cmd_o.mul_second = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cfg_take) begin
          pass_d  = 1'b0;
          state_d = S_LOAD;
        end else if (in_take) begin
          cmd_o.op = OP_STEP;
          state_d  = S_DIV;
        end
      end
      S_LOAD: begin
        cmd_o.op = pass_q ? OP_LOAD_A : OP_LOAD_SEED;
        state_d  = S_X1;
      end
      S_X1: begin
        cmd_o.op = OP_XSHIFT;
        phase_d  = 2'd0;
        state_d  = S_M1;
      end
      S_M1: begin
        cmd_o.op = OP_MUL;
        phase_d  = phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          state_d = S_X2;
        end
      end
      S_X2: begin
        cmd_o.op = OP_XSHIFT;
        phase_d  = 2'd0;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op         = OP_MUL;
        cmd_o.mul_second = 1'b1;
        phase_d          = phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = pass_q ? OP_FINAL_B : OP_FINAL_A;
        if (pass_q) begin
          state_d = S_IDLE;
        end else begin
          pass_d  = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (status_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // reset enters the reload sequence with the reset seed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      phase_q     <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/xorshift128plus_generator.sv =====
// Top level of the xorshift128+ generator with ranged output.
// Depends on xs128p_pkg, xs128p_ctrl, xs128p_datapath.
//
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+-----------------------------
// cfg      | in        | cfg_valid_i/ready_o  | 64-bit seed
// in       | in        | in_valid_i/stall_o   | xs_in_t  {range_min, range_max}
// out      | out       | out_valid_o/stall_i  | xs_out_t {raw_draw, ranged_draw}
//
// Draw sequence: the accepting cycle does the xorshift step, then the
//   64-step restoring remainder loop runs one dividend bit a cycle, then
//   the output register is loaded once it holds no stalled beat.
// Reset and seed writes run the finalizer twice (word a, then word b) on a
//   shared 32x32 multiplier, with input held stalled meanwhile.
// A finished beat waits in the output register; the next input beat is
//   taken meanwhile, and only the next result waits on out_stall_i.
module xorshift128plus_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xs128p_pkg::xs_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xs128p_pkg::xs_out_t out_o
);
  import xs128p_pkg::*;

  xs_cmd_t    cmd;
  xs_status_t status;
  logic       seed_we;

  // seed register loads on the config beat; the controller then reloads state
  assign seed_we = cfg_valid_i && cfg_ready_o;

  xs128p_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // state words, multiplier and remainder unit
  xs128p_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (seed_we),
    .seed_i    (cfg_data_i),
    .in_i      (in_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/xs128p_checker.sv =====
// Port-level checks for the xorshift128+ generator, bound to the top level.
// Depends on xs128p_pkg and xorshift128plus_generator_assert.svh.
`include "xorshift128plus_generator_assert.svh"

module xs128p_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [63:0]         cfg_data_i,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input xs128p_pkg::xs_in_t  in_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input xs128p_pkg::xs_out_t out_o
);
  import xs128p_pkg::*;

  logic in_take, cfg_take;
  logic unused_ok;

  assign in_take   = in_valid_i && !in_stall_o;
  assign cfg_take  = cfg_valid_i && cfg_ready_o;
  assign unused_ok = ^{cfg_data_i, in_i};

  // stalled result beat holds
  `XS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o))
  // a seed write starts a reload: nothing taken next cycle
  `XS_ASSERT_NEXT(a_cfg_busy, cfg_take, in_stall_o && !cfg_ready_o)
  // remainder loop keeps the block busy and no new result appears next cycle
  `XS_ASSERT_NEXT(a_in_busy, in_take, in_stall_o && !$rose(out_valid_o))
  // config and input open together when no config beat is offered
  `XS_ASSERT_NOW(a_idle_match, !cfg_valid_i, cfg_ready_o == !in_stall_o)

endmodule

bind xorshift128plus_generator xs128p_checker u_checker (.*);
